@@ rtl/wse_pkg.sv @@
// shared types and constants for the websocket frame encoder
package wse_pkg;

    localparam int LEN_W = 63;
    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_FRAME = 2'd1,
        ERR_ABANDON  = 2'd2
    } t_err;

    typedef enum logic {
        JOB_HDR  = 1'b0,
        JOB_BYTE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_16   = 2'd1,
        EXT_64   = 2'd2
    } t_ext;

    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
    localparam logic [15:0] LEN_16_MAX  = 16'hffff;

    // one unit of work handed from the front to the back
    typedef struct packed {
        t_kind            kind;
        t_err             err;
        logic             done;
        logic [7:0]       b0;
        logic [7:0]       b1;
        t_ext             ext;
        logic             masked;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_job;

endpackage

@@ rtl/wse_front.sv @@
// front end: takes input items, tracks frame state and builds jobs
module wse_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_func,
    input  logic                     i_fin,
    input  logic [2:0]               i_rsv,
    input  logic [3:0]               i_opcode,
    input  logic                     i_masked,
    input  logic [wse_pkg::LEN_W-1:0] i_payload_length,
    input  logic [wse_pkg::KEY_W-1:0] i_mask_key,
    input  logic [7:0]               i_data_byte,
    output wse_pkg::t_job            o_job
);
    import wse_pkg::*;

    logic             r_open;
    logic [LEN_W-1:0] r_remaining;
    logic [KEY_W-1:0] r_key;
    logic [1:0]       r_kpos;
    logic             r_masking;

    logic             n_open;
    logic [LEN_W-1:0] n_remaining;
    logic [KEY_W-1:0] n_key;
    logic [1:0]       n_kpos;
    logic             n_masking;

    logic             w_direct;
    logic             w_short;
    logic [6:0]       w_code;
    t_ext             w_ext;
    logic [7:0]       w_key_byte;
    logic             w_rem_one;

    always_comb begin
        w_direct   = (i_payload_length[LEN_W-1:7] == '0) &&
                     (i_payload_length[6:0] <= LEN_DIRECT_MAX);
        w_short    = (i_payload_length[LEN_W-1:16] == '0);
        w_key_byte = r_key[{~r_kpos, 3'b000} +: 8];
        w_rem_one  = (r_remaining == {{(LEN_W-1){1'b0}}, 1'b1});
        if (w_direct) begin
            w_code = i_payload_length[6:0];
            w_ext  = EXT_NONE;
        end else if (w_short) begin
            w_code = LEN_CODE_16;
            w_ext  = EXT_16;
        end else begin
            w_code = LEN_CODE_64;
            w_ext  = EXT_64;
        end
    end

    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        n_key       = r_key;
        n_kpos      = r_kpos;
        n_masking   = r_masking;

        o_job        = '0;
        o_job.kind   = JOB_BYTE;
        o_job.err    = ERR_OK;
        o_job.ext    = EXT_NONE;
        o_job.key    = i_mask_key;
        o_job.len    = i_payload_length;

        if (!i_func) begin
            o_job.kind   = JOB_HDR;
            o_job.err    = r_open ? ERR_ABANDON : ERR_OK;
            o_job.done   = (i_payload_length == '0);
            o_job.b0     = {i_fin, i_rsv, i_opcode};
            o_job.b1     = {i_masked, w_code};
            o_job.ext    = w_ext;
            o_job.masked = i_masked;
            n_key        = i_mask_key;
            n_kpos       = 2'd0;
            n_masking    = i_masked;
            n_remaining  = i_payload_length;
            n_open       = (i_payload_length != '0);
        end else if (!r_open) begin
            // stray payload byte: report and leave state alone
            o_job.err = ERR_NO_FRAME;
            o_job.b0  = 8'd0;
        end else begin
            o_job.b0    = r_masking ? (i_data_byte ^ w_key_byte) : i_data_byte;
            o_job.done  = w_rem_one;
            n_kpos      = r_kpos + 2'd1;
            n_remaining = r_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
            n_open      = !w_rem_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= '0;
            r_key       <= '0;
            r_kpos      <= 2'd0;
            r_masking   <= 1'b0;
        end else if (i_accept) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
            r_key       <= n_key;
            r_kpos      <= n_kpos;
            r_masking   <= n_masking;
        end
    end

endmodule

@@ rtl/wse_jobq.sv @@
// short job queue between front and back
module wse_jobq #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  wse_pkg::t_job i_job,
    input  logic          i_rd,
    output wse_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import wse_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

    t_job          r_slot [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/wse_back.sv @@
// back end: serialises jobs into frame bytes behind an output register
module wse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wse_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_frame_done,
    output logic [1:0]    o_error
);
    import wse_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_pos;
    logic [3:0] r_last;
    logic       r_out_v;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_done;
    t_err       r_err;

    logic       w_at_last;
    logic       w_adv;
    logic       w_emit;
    logic       w_load;
    logic [3:0] w_ext_n;
    logic [3:0] w_in_ext_n;
    logic [3:0] n_last;
    logic [3:0] w_j;
    logic [3:0] w_k;
    logic [3:0] w_kj;
    logic [63:0] w_len64;
    logic [7:0] w_byte;

    function automatic logic [3:0] ext_count(input t_ext e);
        logic [3:0] c;
        unique case (e)
            EXT_16:  c = 4'd2;
            EXT_64:  c = 4'd8;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    always_comb begin
        w_at_last  = (r_pos == r_last);
        w_adv      = !r_out_v || i_pop;
        w_emit     = r_busy && w_adv;
        w_load     = (!r_busy || (w_emit && w_at_last)) && !i_job_empty;
        o_job_pop  = w_load;
        w_in_ext_n = ext_count(i_job.ext);
        if (i_job.kind == JOB_HDR) begin
            n_last = 4'd1 + w_in_ext_n + (i_job.masked ? 4'd4 : 4'd0);
        end else begin
            n_last = 4'd0;
        end
    end

    // pick the byte at the current position of a header, or the byte of a payload job
    always_comb begin
        w_ext_n = ext_count(r_job.ext);
        w_len64 = {1'b0, r_job.len};
        w_j     = r_pos - 4'd2;
        w_k     = w_ext_n - 4'd1 - w_j;
        w_kj    = w_j - w_ext_n;
        if (r_job.kind == JOB_BYTE || r_pos == 4'd0) begin
            w_byte = r_job.b0;
        end else if (r_pos == 4'd1) begin
            w_byte = r_job.b1;
        end else if (w_j < w_ext_n) begin
            w_byte = w_len64[{w_k[2:0], 3'b000} +: 8];
        end else begin
            w_byte = r_job.key[{~w_kj[1:0], 3'b000} +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job  <= i_job;
            r_last <= n_last;
        end
        if (w_emit) begin
            r_byte     <= w_byte;
            r_run_last <= w_at_last;
            r_done     <= w_at_last && r_job.done;
            r_err      <= r_job.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= 4'd0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_pos  <= 4'd0;
            end else if (w_emit) begin
                if (w_at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_v;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_run_last;
    assign o_frame_done = r_done;
    assign o_error      = r_err;

endmodule

@@ rtl/websocket_frame_encoder.sv @@
// top level of the websocket client frame encoder
//
// channel  | handshake         | fields
// ---------+-------------------+------------------------------------------------
// input    | push / full       | func fin rsv opcode masked payload_length
//          |                   | mask_key data_byte
// result   | empty / pop       | out_byte run_last frame_done error
//
// a payload item yields one byte; the back end emits one byte per cycle unless pop stalls
// it, so payload streams at one item per cycle, and a header yields 2 to 14 bytes set by
// the byte counter in the back end. first byte passes the queue, job and output registers.
// synchronous active-low reset clears frame state, queue and output register.
// the job queue lets input keep flowing while the result side is stalled, until full.
module websocket_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_func,
    input  logic                      i_fin,
    input  logic [2:0]                i_rsv,
    input  logic [3:0]                i_opcode,
    input  logic                      i_masked,
    input  logic [wse_pkg::LEN_W-1:0] i_payload_length,
    input  logic [wse_pkg::KEY_W-1:0] i_mask_key,
    input  logic [7:0]                i_data_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_frame_done,
    output logic [1:0]                o_error
);
    import wse_pkg::*;

    t_job w_front_job;
    t_job w_q_job;
    logic w_accept;
    logic w_q_empty;
    logic w_q_pop;

    assign w_accept = push && !full;

    wse_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_func           (i_func),
        .i_fin            (i_fin),
        .i_rsv            (i_rsv),
        .i_opcode         (i_opcode),
        .i_masked         (i_masked),
        .i_payload_length (i_payload_length),
        .i_mask_key       (i_mask_key),
        .i_data_byte      (i_data_byte),
        .o_job            (w_front_job)
    );

    wse_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_job   (w_front_job),
        .i_rd    (w_q_pop),
        .o_job   (w_q_job),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    wse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_q_job),
        .i_job_empty  (w_q_empty),
        .o_job_pop    (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .o_error      (o_error)
    );

`ifndef SYNTHESIS
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_done) |-> o_run_last)
        else $error("frame_done without run_last");

    a_stray_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error == ERR_NO_FRAME) |-> (o_run_last && !o_frame_done))
        else $error("stray payload result malformed");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_error == ERR_OK || o_error == ERR_NO_FRAME ||
                    o_error == ERR_ABANDON))
        else $error("undefined error code");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule
